@@ rtl/core/ps2mt_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared widths, constants and register indexes for the PS/2 mouse packet
// tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mt_pkg;

  // Payload widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned BTN_W    = 3;
  localparam int unsigned WHEEL_W  = 4;
  localparam int unsigned DELTA_W  = 10;  // twice a signed byte, either sign
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // Header byte: bit 3 is always set in a valid first byte
  localparam int unsigned SYNC_BIT = 3;

  // Cursor sprite size, subtracted from the screen size to get the limit
  localparam logic [POS_W-1:0] CURSOR_W = POS_W'(12);
  localparam logic [POS_W-1:0] CURSOR_H = POS_W'(18);

  // Power-up cursor position
  localparam logic [POS_W-1:0] POS_X_RESET = POS_W'(320);
  localparam logic [POS_W-1:0] POS_Y_RESET = POS_W'(240);

  // Power-up register values
  localparam logic [POS_W-1:0] WIDTH_RESET  = POS_W'(640);
  localparam logic [POS_W-1:0] HEIGHT_RESET = POS_W'(480);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_MODE    = 2'd0,
    CFG_SCREEN_WIDTH  = 2'd1,
    CFG_SCREEN_HEIGHT = 2'd2
  } cfg_index_t;

endpackage : ps2mt_pkg

`default_nettype wire

@@ rtl/core/ps2mt_move_clamp.sv @@
// ----------------------------------------------------------------------------
// ps2mt_move_clamp
// Adds a signed move to one cursor coordinate and clamps the sum to
// 0..limit, where limit is screen size minus cursor size, floored at 0 and
// capped at the largest coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mt_move_clamp #(
  parameter int COORD_BITS = 12
) (
  input  wire logic        [ps2mt_pkg::POS_W-1:0]   pos,
  input  wire logic signed [ps2mt_pkg::DELTA_W-1:0] delta,
  input  wire logic        [ps2mt_pkg::POS_W-1:0]   screen,
  input  wire logic        [ps2mt_pkg::POS_W-1:0]   margin,
  output logic             [ps2mt_pkg::POS_W-1:0]   pos_next
);

  // Wide enough for the largest cap (16-bit coordinates) plus a sign bit
  localparam int SUM_W = 18;
  localparam int CoordMax = (1 << COORD_BITS) - 1;
  localparam logic signed [SUM_W-1:0] CapVal = SUM_W'(CoordMax);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] limit_raw;
  logic signed [SUM_W-1:0] limit;
  logic signed [SUM_W-1:0] clamped;

  // Moved position and raw limit, both in signed wide form
  assign sum = $signed({{(SUM_W-ps2mt_pkg::POS_W){1'b0}}, pos})
             + $signed({{(SUM_W-ps2mt_pkg::DELTA_W){delta[ps2mt_pkg::DELTA_W-1]}}, delta});
  assign limit_raw = $signed({{(SUM_W-ps2mt_pkg::POS_W){1'b0}}, screen})
                   - $signed({{(SUM_W-ps2mt_pkg::POS_W){1'b0}}, margin});

  // Floor and cap the limit, then clamp the position into 0..limit
  always_comb begin
    limit = limit_raw;
    if (limit < 0) begin
      limit = '0;
    end
    if (limit > CapVal) begin
      limit = CapVal;
    end
    clamped = sum;
    if (clamped < 0) begin
      clamped = '0;
    end
    if (clamped > limit) begin
      clamped = limit;
    end
  end

  assign pos_next = clamped[ps2mt_pkg::POS_W-1:0];

endmodule : ps2mt_move_clamp

`default_nettype wire

@@ rtl/core/ps2_mouse_packet_tracker.sv @@
// A byte goes from the input register to the result register; out_stall can hold it.
// Throughput: one byte per cycle unless out_stall holds the result register.
// Each accepted byte produces exactly one result transaction.
// Reset (rst, synchronous): empty pipeline, awaiting a header byte, cursor at
// 320,240, no buttons, zero wheel, three-byte packets, screen 640x480.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Frames PS/2 mouse packets (three bytes, or four with the wheel byte),
// tracks buttons, wheel and a clamped cursor position.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_tracker #(
  parameter int COORD_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst,

  // Configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [ps2mt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ps2mt_pkg::CFG_DATA_W-1:0]    cfg_data,

  // Received byte channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ps2mt_pkg::BYTE_W-1:0]        rx_byte,

  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic        [ps2mt_pkg::POS_W-1:0]       cursor_x,
  output logic        [ps2mt_pkg::POS_W-1:0]       cursor_y,
  output logic        [ps2mt_pkg::BTN_W-1:0]       button_bits,
  output logic signed [ps2mt_pkg::WHEEL_W-1:0]     scroll_delta,
  output logic                                     packet_done
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XDATA  = 2'd1,
    PH_YDATA  = 2'd2,
    PH_WHEEL  = 2'd3
  } phase_t;

  // Configuration registers
  logic                           wheel_mode;
  logic [ps2mt_pkg::POS_W-1:0]    screen_width;
  logic [ps2mt_pkg::POS_W-1:0]    screen_height;

  // Input register
  logic                           s1_valid;
  logic [ps2mt_pkg::BYTE_W-1:0]   s1_byte;

  // Tracker state
  phase_t                         byte_phase;
  logic [ps2mt_pkg::BYTE_W-1:0]   header_byte;
  logic [ps2mt_pkg::BYTE_W-1:0]   x_delta_byte;
  logic [ps2mt_pkg::POS_W-1:0]    pos_x;
  logic [ps2mt_pkg::POS_W-1:0]    pos_y;
  logic [ps2mt_pkg::BTN_W-1:0]    buttons_held;
  logic [ps2mt_pkg::WHEEL_W-1:0]  wheel_value;

  // Next-state values
  phase_t                         byte_phase_next;
  logic [ps2mt_pkg::BYTE_W-1:0]   header_byte_next;
  logic [ps2mt_pkg::BYTE_W-1:0]   x_delta_byte_next;
  logic [ps2mt_pkg::POS_W-1:0]    pos_x_next;
  logic [ps2mt_pkg::POS_W-1:0]    pos_y_next;
  logic [ps2mt_pkg::BTN_W-1:0]    buttons_held_next;
  logic [ps2mt_pkg::WHEEL_W-1:0]  wheel_value_next;
  logic                           done_next;

  logic                           out_ready;
  logic                           advance;
  logic signed [ps2mt_pkg::DELTA_W-1:0] dx;
  logic signed [ps2mt_pkg::DELTA_W-1:0] dy;
  logic [ps2mt_pkg::POS_W-1:0]    moved_x;
  logic [ps2mt_pkg::POS_W-1:0]    moved_y;

  // Handshake: the result register frees when empty or taken
  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_mode    <= 1'b0;
      screen_width  <= ps2mt_pkg::WIDTH_RESET;
      screen_height <= ps2mt_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ps2mt_pkg::CFG_WHEEL_MODE:    wheel_mode    <= cfg_data[0];
        ps2mt_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[ps2mt_pkg::POS_W-1:0];
        ps2mt_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[ps2mt_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  // Moves: X doubled, Y doubled and negated
  assign dx = $signed({x_delta_byte[7], x_delta_byte, 1'b0});
  assign dy = -$signed({s1_byte[7], s1_byte, 1'b0});

  ps2mt_move_clamp #(
    .COORD_BITS (COORD_BITS)
  ) u_clamp_x (
    .pos      (pos_x),
    .delta    (dx),
    .screen   (screen_width),
    .margin   (ps2mt_pkg::CURSOR_W),
    .pos_next (moved_x)
  );

  ps2mt_move_clamp #(
    .COORD_BITS (COORD_BITS)
  ) u_clamp_y (
    .pos      (pos_y),
    .delta    (dy),
    .screen   (screen_height),
    .margin   (ps2mt_pkg::CURSOR_H),
    .pos_next (moved_y)
  );

  // Packet framing
  always_comb begin
    byte_phase_next   = byte_phase;
    header_byte_next  = header_byte;
    x_delta_byte_next = x_delta_byte;
    pos_x_next        = pos_x;
    pos_y_next        = pos_y;
    buttons_held_next = buttons_held;
    wheel_value_next  = wheel_value;
    done_next         = 1'b0;
    unique case (byte_phase)
      PH_HEADER: begin
        // Bytes without the sync bit are dropped to regain framing
        if (s1_byte[ps2mt_pkg::SYNC_BIT]) begin
          wheel_value_next = '0;
          header_byte_next = s1_byte;
          byte_phase_next  = PH_XDATA;
        end
      end
      PH_XDATA: begin
        x_delta_byte_next = s1_byte;
        byte_phase_next   = PH_YDATA;
      end
      PH_YDATA: begin
        buttons_held_next = header_byte[ps2mt_pkg::BTN_W-1:0];
        pos_x_next        = moved_x;
        pos_y_next        = moved_y;
        if (wheel_mode) begin
          byte_phase_next = PH_WHEEL;
        end else begin
          byte_phase_next = PH_HEADER;
          done_next       = 1'b1;
        end
      end
      PH_WHEEL: begin
        wheel_value_next = s1_byte[ps2mt_pkg::WHEEL_W-1:0];
        byte_phase_next  = PH_HEADER;
        done_next        = 1'b1;
      end
    endcase
  end

  // Tracker state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= PH_HEADER;
      header_byte  <= '0;
      x_delta_byte <= '0;
      pos_x        <= ps2mt_pkg::POS_X_RESET;
      pos_y        <= ps2mt_pkg::POS_Y_RESET;
      buttons_held <= '0;
      wheel_value  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        byte_phase   <= byte_phase_next;
        header_byte  <= header_byte_next;
        x_delta_byte <= x_delta_byte_next;
        pos_x        <= pos_x_next;
        pos_y        <= pos_y_next;
        buttons_held <= buttons_held_next;
        wheel_value  <= wheel_value_next;
        cursor_x     <= pos_x_next;
        cursor_y     <= pos_y_next;
        button_bits  <= buttons_held_next;
        scroll_delta <= $signed(wheel_value_next);
        packet_done  <= done_next;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule : ps2_mouse_packet_tracker

`default_nettype wire
